@@ rtl/core/hdlc_pkg.sv @@
// Shared types, constants and the hex digit helper function for the hex dump line checker.
package hdlc_pkg;

    localparam int HDLC_COUNT_WIDTH = 32;

    localparam int CH_W = 8;
    localparam int KIND_W = 2;
    localparam int LINE_W = 16;
    localparam int PHASE_W = 2;
    localparam int ACCUM_W = 32;
    localparam int TLEN_W = 4;
    localparam int TCHARS_W = 24;

    localparam logic [PHASE_W-1:0] PH_OFFSET = 2'd0;
    localparam logic [PHASE_W-1:0] PH_BYTES = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TEXT = 2'd2;
    localparam logic [PHASE_W-1:0] PH_REJECT = 2'd3;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_BYTE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_LINE = 2'd3;

    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_NL = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR = 8'h0D;

    localparam logic [TLEN_W-1:0] TLEN_MAX = 4'd15;
    localparam logic [1:0] EMPTY_LIMIT = 2'd3;
    localparam logic [LINE_W-1:0] LINE_MAX = 16'hFFFF;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [TCHARS_W-1:0] chars;
        logic [TLEN_W-1:0]   length;
        logic [ACCUM_W-1:0]  accum;
        logic                overflow;
    } tok_t;

    function automatic hex_t hex_digit(input logic [CH_W-1:0] c);
        hex_t h;
        h.ok = 1'b0;
        h.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok = 1'b1;
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            h.ok = 1'b1;
            h.val = 4'(c[3:0] + 4'd9);
        end
        return h;
    endfunction

endpackage

@@ rtl/core/hdlc_token.sv @@
// Token collector: gathers the characters and the hex offset value of the current token.
module hdlc_token
    import hdlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [CH_W-1:0]    ch,
    input  logic               offset_phase,
    output tok_t               tok
);

    tok_t tok_reg;
    tok_t tok_next;
    hex_t hd;

    assign tok = tok_reg;

    always_comb
    begin
        tok_next = tok_reg;
        hd = hex_digit(ch);
        if (ch == CH_SPACE || ch == CH_NL)
        begin
            tok_next = '0;
        end
        else
        begin
            case (tok_reg.length)
                4'd0: tok_next.chars[7:0] = tok_reg.chars[7:0] | ch;
                4'd1: tok_next.chars[15:8] = tok_reg.chars[15:8] | ch;
                4'd2: tok_next.chars[23:16] = tok_reg.chars[23:16] | ch;
                default: tok_next.chars = tok_reg.chars;
            endcase
            if (tok_reg.length != TLEN_MAX)
            begin
                tok_next.length = tok_reg.length + 4'd1;
            end
            if (offset_phase && ch != CH_CR)
            begin
                if (!hd.ok || tok_reg.accum[ACCUM_W-1:ACCUM_W-4] != 4'd0)
                begin
                    tok_next.overflow = 1'b1;
                end
                else
                begin
                    tok_next.accum = {tok_reg.accum[ACCUM_W-5:0], hd.val};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (step)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

@@ rtl/core/hex_dump_line_checker_unit.sv @@
// Top level of the hex dump line checker: line state, token evaluation and stream ports.
// The input stream carries one ASCII character of a hex dump per transaction.
// Spaces end tokens and newlines end lines; the first token of a line is an
// offset, and the later two-digit tokens are data bytes.
// The output stream carries zero or one result per character: a data byte, a
// frame start, a bad byte token or a rejected offset line, with the line number.
// A character is taken into an input register, evaluated by combinational logic
// and its result is stored in an output register.
// One character is accepted in every cycle while the receiver does not stall;
// the rate is set by the single token evaluation stage between the two registers.
// When the receiver stalls, the output register holds its result and the input
// register holds the next character; input stops only when both are full.
// Reset empties both registers, clears the byte counts and the token, sets the
// line number to one and waits for an offset token.
module hex_dump_line_checker_unit
    import hdlc_pkg::*;
#(
    parameter int COUNT_WIDTH = HDLC_COUNT_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // value[7:0], line_number[23:8]
    output logic [1:0]  m_tuser    // kind[1:0]
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [CH_W-1:0]        in_ch_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [23:0]            out_data_reg;
    logic [KIND_W-1:0]      out_kind_reg;

    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic [1:0]             empty_reg;
    logic [1:0]             empty_next;
    logic [COUNT_WIDTH-1:0] bc_reg;
    logic [COUNT_WIDTH-1:0] bc_next;
    logic [COUNT_WIDTH-1:0] lbc_reg;
    logic [COUNT_WIDTH-1:0] lbc_next;
    logic [LINE_W-1:0]      line_reg;
    logic [LINE_W-1:0]      line_next;

    logic                   advance;
    logic                   is_space;
    logic                   is_nl;
    logic                   res_valid;
    logic [KIND_W-1:0]      res_kind;
    logic [CH_W-1:0]        res_value;
    logic                   offset_match;
    logic                   byte_ok;
    hex_t                   hi_digit;
    hex_t                   lo_digit;
    tok_t                   tok;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_kind_reg;

    hdlc_token u_token (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .ch           (in_ch_reg),
        .offset_phase (phase_reg == PH_OFFSET),
        .tok          (tok)
    );

    assign is_space = (in_ch_reg == CH_SPACE);
    assign is_nl = (in_ch_reg == CH_NL);
    assign offset_match = (tok.accum[COUNT_WIDTH-1:0] == bc_reg)
                          && ((tok.accum >> COUNT_WIDTH) == '0);
    assign hi_digit = hex_digit(tok.chars[7:0]);
    assign lo_digit = hex_digit(tok.chars[15:8]);
    assign byte_ok = hi_digit.ok && lo_digit.ok
                     && (tok.length == 4'd2
                         || (tok.length == 4'd3 && tok.chars[23:16] == CH_CR));

    always_comb
    begin
        phase_next = phase_reg;
        empty_next = empty_reg;
        bc_next = bc_reg;
        lbc_next = lbc_reg;
        line_next = line_reg;
        res_valid = 1'b0;
        res_kind = KIND_DATA;
        res_value = '0;
        if (is_space || is_nl)
        begin
            case (phase_reg)
                PH_OFFSET:
                begin
                    phase_next = PH_BYTES;
                    if (tok.length >= 4'd2)
                    begin
                        if (!tok.overflow && tok.accum == '0)
                        begin
                            bc_next = '0;
                            lbc_next = '0;
                            res_valid = 1'b1;
                            res_kind = KIND_FRAME;
                        end
                        else if (!(!tok.overflow && offset_match))
                        begin
                            phase_next = PH_REJECT;
                        end
                    end
                end
                PH_BYTES:
                begin
                    if (empty_reg >= EMPTY_LIMIT)
                    begin
                        phase_next = PH_TEXT;
                    end
                    else if (tok.length < 4'd2)
                    begin
                        empty_next = empty_reg + 2'd1;
                    end
                    else if (byte_ok)
                    begin
                        lbc_next = lbc_reg + COUNT_WIDTH'(1);
                        res_valid = 1'b1;
                        res_kind = KIND_DATA;
                        res_value = {hi_digit.val, lo_digit.val};
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res_kind = KIND_BAD_BYTE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (is_nl)
            begin
                if (phase_next == PH_REJECT)
                begin
                    res_valid = 1'b1;
                    res_kind = KIND_BAD_LINE;
                    res_value = '0;
                end
                else
                begin
                    bc_next = bc_next + lbc_next;
                end
                lbc_next = '0;
                empty_next = '0;
                phase_next = PH_OFFSET;
                if (line_reg != LINE_MAX)
                begin
                    line_next = line_reg + 16'd1;
                end
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg <= PH_OFFSET;
            empty_reg <= '0;
            bc_reg <= '0;
            lbc_reg <= '0;
            line_reg <= 16'd1;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                empty_reg <= empty_next;
                bc_reg <= bc_next;
                lbc_reg <= lbc_next;
                line_reg <= line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_ch_reg <= s_tdata;
        end
        if (advance && res_valid)
        begin
            out_data_reg <= {line_reg, res_value};
            out_kind_reg <= res_kind;
        end
    end

endmodule
